[src/rcps_pkg.sv]
// Shared constants for the raycast column pixel shader.
// Pixel kinds, register indexes and cosine table constants; no dependencies.
package rcps_pkg;

    // pixel kinds
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_WALL  = 2'd1;
    localparam logic [1:0] KIND_CEIL  = 2'd2;
    localparam logic [1:0] KIND_FLOOR = 2'd3;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_SCREEN_HEIGHT   = 3'd0;
    localparam logic [2:0] REG_CELL_SIZE       = 3'd1;
    localparam logic [2:0] REG_TEX_HEIGHT      = 3'd2;
    localparam logic [2:0] REG_CEILING_COLOR   = 3'd3;
    localparam logic [2:0] REG_FLOOR_COLOR     = 3'd4;
    localparam logic [2:0] REG_LINE_STRIDE     = 3'd5;
    localparam logic [2:0] REG_TEX_LINE_STRIDE = 3'd6;
    localparam logic [2:0] REG_PIXEL_BYTES     = 3'd7;

    // cosine series constants, Q2.30, and cosine one in Q1.16
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;
    localparam logic [16:0] COS_ONE_Q16 = 17'd65536;

endpackage

[src/rcps_cos_rom.sv]
// Quarter-wave cosine ROM, Q1.16, with angle folding and a registered read.
// Depends on rcps_pkg; table contents are worked out at elaboration.
module rcps_cos_rom
    import rcps_pkg::*;
#(
    parameter int ANGLE_BITS = 12
)
(
    input  logic                  clk,
    input  logic                  en,
    input  logic [ANGLE_BITS-1:0] angle,
    output logic [16:0]           cos_q16,
    output logic                  cos_pos
);

    localparam logic [ANGLE_BITS-1:0] HALF    = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
    localparam logic [ANGLE_BITS-1:0] QUART   = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
    localparam logic [63:0]           QUARTER = 64'(1) << (ANGLE_BITS - 2);

    function automatic logic [16:0] cos_entry(input int unsigned a);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] c;
        longint      sum;
        x    = (64'(a) * HALF_PI_Q30) / QUARTER;
        x2   = (x * x) >> 30;
        term = ONE_Q30;
        sum  = longint'(ONE_Q30);
        for (int k = 1; k <= 7; k++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
            if ((k % 2) == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        c = (64'(sum) + 64'd8192) >> 14;
        if (c > 64'(COS_ONE_Q16))
            c = 64'(COS_ONE_Q16);
        return c[16:0];
    endfunction

    logic [16:0] rom [int'(QUARTER) + 1];

    for (genvar gi = 0; gi <= int'(QUARTER); gi++)
    begin : g_rom
        assign rom[gi] = cos_entry(gi);
    end

    logic [ANGLE_BITS-1:0] a_fold;
    logic [ANGLE_BITS-1:0] a_quad;
    logic                  neg;

    always_comb
    begin
        a_fold = (angle > HALF) ? (~angle + ANGLE_BITS'(1)) : angle;
        neg    = a_fold > QUART;
        a_quad = neg ? (HALF - a_fold) : a_fold;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_q16 <= rom[a_quad[ANGLE_BITS-2:0]];
            cos_pos <= !neg;
        end
    end

endmodule

[src/rcps_divider.sv]
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Needs dividend < divisor << Q_W; no package dependencies.
module rcps_divider #(
    parameter int N_W  = 39,
    parameter int D_W  = 24,
    parameter int Q_W  = 39,
    parameter int SB_W = 8
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_vld,
    input  logic [N_W-1:0]  dividend,
    input  logic [D_W-1:0]  divisor,
    input  logic [SB_W-1:0] in_sb,
    output logic            out_vld,
    output logic [Q_W-1:0]  quotient,
    output logic [SB_W-1:0] out_sb
);

    logic            v_reg   [Q_W];
    logic [D_W-1:0]  rem_reg [Q_W];
    logic [Q_W-1:0]  q_reg   [Q_W];
    logic [N_W-1:0]  n_reg   [Q_W];
    logic [D_W-1:0]  d_reg   [Q_W];
    logic [SB_W-1:0] sb_reg  [Q_W];

    for (genvar g = 0; g < Q_W; g++)
    begin : g_stage
        localparam int B = Q_W - 1 - g;

        logic            v_in;
        logic [D_W-1:0]  rem_in;
        logic [Q_W-1:0]  q_in;
        logic [N_W-1:0]  n_in;
        logic [D_W-1:0]  d_in;
        logic [SB_W-1:0] sb_in;
        logic [D_W:0]    trial;
        logic            ge;
        logic [D_W-1:0]  rem_next;
        logic [Q_W-1:0]  q_next;

        if (g == 0)
        begin : g_first
            assign v_in   = in_vld;
            assign rem_in = D_W'(dividend >> Q_W);
            assign q_in   = '0;
            assign n_in   = dividend;
            assign d_in   = divisor;
            assign sb_in  = in_sb;
        end
        else
        begin : g_rest
            assign v_in   = v_reg[g-1];
            assign rem_in = rem_reg[g-1];
            assign q_in   = q_reg[g-1];
            assign n_in   = n_reg[g-1];
            assign d_in   = d_reg[g-1];
            assign sb_in  = sb_reg[g-1];
        end

        assign trial    = {rem_in, n_in[B]};
        assign ge       = trial >= {1'b0, d_in};
        assign rem_next = ge ? D_W'(trial - {1'b0, d_in}) : trial[D_W-1:0];

        always_comb
        begin
            q_next    = q_in;
            q_next[B] = ge;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[g] <= 1'b0;
            else if (en)
                v_reg[g] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g] <= rem_next;
                q_reg[g]   <= q_next;
                n_reg[g]   <= n_in;
                d_reg[g]   <= d_in;
                sb_reg[g]  <= sb_in;
            end
        end
    end

    assign out_vld  = v_reg[Q_W-1];
    assign quotient = q_reg[Q_W-1];
    assign out_sb   = sb_reg[Q_W-1];

endmodule

[src/raycast_column_pixel_shader_top.sv]
// Throughput: one pixel per clock while the skid is empty; set by the two bit-per-stage dividers.
// A two-entry output buffer (register plus skid) lets input run while a result waits.
// Reset: asynchronous, active low; clears all valid bits and loads register defaults.
// Needs rcps_pkg, rcps_cos_rom, rcps_divider.
module raycast_column_pixel_shader_top
    import rcps_pkg::*;
#(
    parameter int ROW_BITS   = 11,
    parameter int ANGLE_BITS = 12,
    parameter int TEX_BITS   = 10
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // APB-style register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // pixel input
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [ROW_BITS-1:0]   row,
    input  logic [11:0]           column,
    input  logic [23:0]           ray_dist,
    input  logic [ANGLE_BITS-1:0] view_angle_diff,
    input  logic [1:0]            wall_side,
    input  logic [TEX_BITS-1:0]   tex_column,
    // pixel result
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            kind,
    output logic [31:0]           pixel_offset,
    output logic [31:0]           color,
    output logic [1:0]            texture_select,
    output logic [TEX_BITS-1:0]   tex_row,
    output logic [31:0]           texel_offset
);

    localparam int RB    = ROW_BITS;
    localparam int TB    = TEX_BITS;
    localparam int H_W   = 12 + RB + 16;        // projected height, Q.8
    localparam int S8_W  = RB + 8;              // row units in Q.8
    localparam int SW    = RB + 11;             // signed working width
    localparam int SB1_W = RB + 2 + TB + 32;
    localparam int SB2_W = 2 + 2 + TB + 32;
    localparam int OUT_W = 2 + 32 + 32 + 2 + TB + 32;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [RB-1:0] screen_height_reg;
    logic [11:0]   cell_size_reg;
    logic [TB-1:0] tex_height_reg;
    logic [31:0]   ceiling_color_reg;
    logic [31:0]   floor_color_reg;
    logic [15:0]   line_stride_reg;
    logic [15:0]   tex_line_stride_reg;
    logic [3:0]    pixel_bytes_reg;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_height_reg   <= RB'(480);
            cell_size_reg       <= 12'd64;
            tex_height_reg      <= TB'(64);
            ceiling_color_reg   <= 32'd0;
            floor_color_reg     <= 32'd0;
            line_stride_reg     <= 16'd2560;
            tex_line_stride_reg <= 16'd256;
            pixel_bytes_reg     <= 4'd4;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_SCREEN_HEIGHT:   screen_height_reg   <= pwdata[RB-1:0];
                REG_CELL_SIZE:       cell_size_reg       <= pwdata[11:0];
                REG_TEX_HEIGHT:      tex_height_reg      <= pwdata[TB-1:0];
                REG_CEILING_COLOR:   ceiling_color_reg   <= pwdata;
                REG_FLOOR_COLOR:     floor_color_reg     <= pwdata;
                REG_LINE_STRIDE:     line_stride_reg     <= pwdata[15:0];
                REG_TEX_LINE_STRIDE: tex_line_stride_reg <= pwdata[15:0];
                REG_PIXEL_BYTES:     pixel_bytes_reg     <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_SCREEN_HEIGHT:   prdata = 32'(screen_height_reg);
            REG_CELL_SIZE:       prdata = 32'(cell_size_reg);
            REG_TEX_HEIGHT:      prdata = 32'(tex_height_reg);
            REG_CEILING_COLOR:   prdata = ceiling_color_reg;
            REG_FLOOR_COLOR:     prdata = floor_color_reg;
            REG_LINE_STRIDE:     prdata = 32'(line_stride_reg);
            REG_TEX_LINE_STRIDE: prdata = 32'(tex_line_stride_reg);
            REG_PIXEL_BYTES:     prdata = 32'(pixel_bytes_reg);
            default:             prdata = 32'd0;
        endcase
    end

    // cell_size * screen_height, static between frames
    logic [12+RB-1:0] cs_s_reg;

    always_ff @(posedge clk)
    begin
        cs_s_reg <= (12+RB)'(cell_size_reg * screen_height_reg);
    end

    // ---------------------------------------------------------------
    // Pipeline enable: the whole pipe holds only once the skid is full
    // ---------------------------------------------------------------
    logic en;
    logic skid_v_reg;

    assign en       = !skid_v_reg;
    assign in_ready = en;

    // ---------------------------------------------------------------
    // Stage 1: capture, frame-buffer offset
    // ---------------------------------------------------------------
    logic                  v1_reg;
    logic [ANGLE_BITS-1:0] ang1_reg;
    logic [23:0]           dist1_reg;
    logic [SB1_W-1:0]      sb1_reg;
    logic [31:0]           pix_off;

    assign pix_off = 32'(row * line_stride_reg) + 32'(column * pixel_bytes_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang1_reg  <= view_angle_diff;
            dist1_reg <= ray_dist;
            sb1_reg   <= {row, wall_side, tex_column, pix_off};
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: cosine lookup
    // ---------------------------------------------------------------
    logic             v2_reg;
    logic [23:0]      dist2_reg;
    logic [SB1_W-1:0] sb2_reg;
    logic [16:0]      cos_q16;
    logic             cos_pos;

    rcps_cos_rom #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_cos (
        .clk     (clk),
        .en      (en),
        .angle   (ang1_reg),
        .cos_q16 (cos_q16),
        .cos_pos (cos_pos)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dist2_reg <= dist1_reg;
            sb2_reg   <= sb1_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: fish-eye corrected distance; at least one
    // ---------------------------------------------------------------
    logic             v3_reg;
    logic [23:0]      d3_reg;
    logic [SB1_W-1:0] sb3_reg;
    logic [40:0]      dprod;
    logic [23:0]      d_next;

    always_comb
    begin
        dprod  = 41'(dist2_reg) * 41'(cos_q16);
        d_next = dprod[39:16];
        if (!cos_pos || d_next == 24'd0)
            d_next = 24'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d3_reg  <= d_next;
            sb3_reg <= sb2_reg;
        end
    end

    // ---------------------------------------------------------------
    // Height divider: H = cell_size * S * 65536 / D
    // ---------------------------------------------------------------
    logic             hv;
    logic [H_W-1:0]   hq;
    logic [SB1_W-1:0] hsb;

    rcps_divider #(
        .N_W  (H_W),
        .D_W  (24),
        .Q_W  (H_W),
        .SB_W (SB1_W)
    ) u_hdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (v3_reg),
        .dividend ({cs_s_reg, 16'd0}),
        .divisor  (d3_reg),
        .in_sb    (sb3_reg),
        .out_vld  (hv),
        .quotient (hq),
        .out_sb   (hsb)
    );

    // ---------------------------------------------------------------
    // C1: clipping, wall offset
    // ---------------------------------------------------------------
    logic [S8_W-1:0] s256;
    logic [S8_W-1:0] half_s;

    assign s256   = {screen_height_reg, 8'd0};
    assign half_s = {screen_height_reg >> 1, 8'd0};

    logic                   c1_v_reg;
    logic [H_W-1:0]         c1_h_reg;
    logic                   c1_clip_reg;
    logic [S8_W-1:0]        c1_hs_reg;
    logic [S8_W-1:0]        c1_ow_reg;
    logic signed [SW-1:0]   c1_o2_reg;
    logic [H_W-1:0]         c1_hm_reg;
    logic [SB1_W-1:0]       c1_sb_reg;

    logic                   clip;
    logic [H_W-1:0]         hh;
    logic [S8_W-1:0]        o_val;

    always_comb
    begin
        clip  = hq > H_W'(s256);
        hh    = hq >> 1;
        o_val = (H_W'(half_s) > hh) ? S8_W'(H_W'(half_s) - hh) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c1_v_reg <= 1'b0;
        else if (en)
            c1_v_reg <= hv;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_h_reg    <= hq;
            c1_clip_reg <= clip;
            c1_hs_reg   <= clip ? s256 : hq[S8_W-1:0];
            c1_ow_reg   <= clip ? '0 : o_val;
            // clipped: (S>>1)*256 - S*128, i.e. -128 on an odd screen
            c1_o2_reg   <= clip ? (screen_height_reg[0] ? -SW'(128) : '0)
                                : $signed(SW'(o_val));
            c1_hm_reg   <= clip ? ((hq - H_W'(s256)) >> 1) : '0;
            c1_sb_reg   <= hsb;
        end
    end

    // ---------------------------------------------------------------
    // C2: classification, texel numerator
    // ---------------------------------------------------------------
    logic [RB-1:0]        c1_row;
    logic [S8_W-1:0]      r256;
    logic signed [SW-1:0] r256_s;
    logic signed [SW-1:0] row_s;
    logic signed [SW-1:0] sum2;
    logic signed [SW-1:0] base;
    logic                 is_wall;
    logic                 is_ceil;
    logic                 is_floor;
    logic                 num_pos;
    logic [H_W-1:0]       num;
    logic [1:0]           kind_next;

    assign c1_row = c1_sb_reg[SB1_W-1 -: RB];
    assign r256   = {c1_row, 8'd0};
    assign r256_s = $signed(SW'(r256));
    assign row_s  = $signed(SW'(c1_row));

    always_comb
    begin
        is_wall = (c1_row >= RB'(c1_ow_reg >> 8))
               && ((S8_W+1)'(r256) < (S8_W+1)'(c1_ow_reg) + (S8_W+1)'(c1_hs_reg));
        if (c1_clip_reg)
        begin
            num     = c1_hm_reg + H_W'(r256);
            num_pos = num != '0;
        end
        else
        begin
            num     = H_W'(r256 - c1_ow_reg);
            num_pos = r256 > c1_ow_reg;
        end
        sum2     = $signed(SW'(c1_hs_reg)) + c1_o2_reg;
        is_ceil  = r256_s < ($signed(SW'(s256)) - sum2);
        base     = sum2 >>> 8;
        // floor limit goes negative on a short offset, so compare signed
        is_floor = (row_s >= base)
                && ((r256_s - (base <<< 8)) < (c1_o2_reg - $signed(SW'(256))));
        if (is_floor)
            kind_next = KIND_FLOOR;
        else if (is_ceil)
            kind_next = KIND_CEIL;
        else if (is_wall)
            kind_next = KIND_WALL;
        else
            kind_next = KIND_NONE;
    end

    logic             c2_v_reg;
    logic [1:0]       c2_kind_reg;
    logic [H_W-1:0]   c2_num_reg;
    logic             c2_ten_reg;
    logic [H_W-1:0]   c2_h_reg;
    logic [SB1_W-1:0] c2_sb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c2_v_reg <= 1'b0;
        else if (en)
            c2_v_reg <= c1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c2_kind_reg <= kind_next;
            c2_num_reg  <= num;
            c2_ten_reg  <= is_wall && num_pos && (c1_h_reg != '0);
            c2_h_reg    <= c1_h_reg;
            c2_sb_reg   <= c1_sb_reg;
        end
    end

    // ---------------------------------------------------------------
    // C3: texel dividend num * T; a dead row divides zero by one
    // ---------------------------------------------------------------
    logic                c3_v_reg;
    logic [H_W+TB-1:0]   c3_n_reg;
    logic [H_W-1:0]      c3_d_reg;
    logic [SB2_W-1:0]    c3_sb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c3_v_reg <= 1'b0;
        else if (en)
            c3_v_reg <= c2_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c3_n_reg  <= c2_ten_reg ? (H_W+TB)'(c2_num_reg * tex_height_reg) : '0;
            c3_d_reg  <= c2_ten_reg ? c2_h_reg : H_W'(1);
            // kind, side, texture column, pixel offset
            c3_sb_reg <= {c2_kind_reg, c2_sb_reg[SB1_W-RB-1:0]};
        end
    end

    // ---------------------------------------------------------------
    // Texel row divider: num * T / H, below T
    // ---------------------------------------------------------------
    logic             tv;
    logic [TB-1:0]    ty;
    logic [SB2_W-1:0] tsb;

    rcps_divider #(
        .N_W  (H_W + TB),
        .D_W  (H_W),
        .Q_W  (TB),
        .SB_W (SB2_W)
    ) u_tdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (c3_v_reg),
        .dividend (c3_n_reg),
        .divisor  (c3_d_reg),
        .in_sb    (c3_sb_reg),
        .out_vld  (tv),
        .quotient (ty),
        .out_sb   (tsb)
    );

    // ---------------------------------------------------------------
    // Result assembly
    // ---------------------------------------------------------------
    logic [1:0]       e_kind;
    logic [1:0]       e_side;
    logic [TB-1:0]    e_tcol;
    logic [31:0]      e_pix;
    logic [31:0]      e_color;
    logic [31:0]      e_texel;
    logic [OUT_W-1:0] e_data;
    logic             e_wall;

    assign {e_kind, e_side, e_tcol, e_pix} = tsb;
    assign e_wall = e_kind == KIND_WALL;

    always_comb
    begin
        case (e_kind)
            KIND_FLOOR: e_color = floor_color_reg;
            KIND_CEIL:  e_color = ceiling_color_reg;
            default:    e_color = 32'd0;
        endcase
        e_texel = 32'(ty * tex_line_stride_reg) + 32'(e_tcol * pixel_bytes_reg);
        e_data  = {e_kind, e_pix, e_color,
                   e_wall ? (e_side ^ 2'b10) : 2'b00,
                   e_wall ? ty : '0,
                   e_wall ? e_texel : 32'd0};
    end

    // ---------------------------------------------------------------
    // Output register with skid entry
    // ---------------------------------------------------------------
    logic             out_v_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic [OUT_W-1:0] skid_data_reg;
    logic             out_take;

    assign out_take = !out_v_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (out_take)
        begin
            if (skid_v_reg)
            begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end
            else
                out_v_reg <= tv;
        end
        else if (tv && en)
            skid_v_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_take)
            out_data_reg <= skid_v_reg ? skid_data_reg : e_data;
        else if (tv && en)
            skid_data_reg <= e_data;
    end

    assign out_valid = out_v_reg;
    assign {kind, pixel_offset, color, texture_select, tex_row, texel_offset} = out_data_reg;

endmodule

[src/rcps_checker.sv]
// Port-level checks for the raycast column pixel shader, bound to the top level.
// Depends on rcps_pkg and raycast_column_pixel_shader_top.
module rcps_checker
    import rcps_pkg::*;
#(
    parameter int TEX_BITS   = 10
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [1:0]            kind,
    input logic [31:0]           pixel_offset,
    input logic [31:0]           color,
    input logic [1:0]            texture_select,
    input logic [TEX_BITS-1:0]   tex_row,
    input logic [31:0]           texel_offset
);

    // nothing can leave the pipe straight after reset
    a_reset_empty: assert property (@(posedge clk) $rose(rst_n) |-> !out_valid)
        else $error("result valid straight after reset");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(pixel_offset)
            && $stable(color) && $stable(tex_row) && $stable(texel_offset))
        else $error("stalled result changed");

    a_texel_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_WALL |->
            texture_select == 2'b00 && tex_row == '0 && texel_offset == 32'd0)
        else $error("texture fields set on a non-wall pixel");

    a_colour_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_WALL || kind == KIND_NONE) |-> color == 32'd0)
        else $error("colour set on a wall or untouched pixel");

endmodule

bind raycast_column_pixel_shader_top rcps_checker #(
    .TEX_BITS   (TEX_BITS)
) u_rcps_checker (.*);

[test/raycast_column_pixel_shader_top_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for the raycast column pixel shader: random pixels and register
// settings, a built-in shading predictor and an in-order result check. Needs rcps_pkg.
module raycast_column_pixel_shader_top_tb;
    import rcps_pkg::*;

    localparam int ROW_W   = 11;
    localparam int ANG_W   = 12;
    localparam int TEXW    = 10;
    localparam int LATENCY = ROW_W + TEXW + 35;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [11:0]      column;
        logic [23:0]      ray_dist;
        logic [ANG_W-1:0] angle;
        logic [1:0]       side;
        logic [TEXW-1:0]  tcol;
    } pixel_t;

    typedef struct packed {
        logic [1:0]      kind;
        logic [31:0]     pix_off;
        logic [31:0]     color;
        logic [1:0]      tsel;
        logic [TEXW-1:0] trow;
        logic [31:0]     texel_off;
    } shade_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [ROW_W-1:0] row = '0;
    logic [11:0]      column = '0;
    logic [23:0]      ray_dist = '0;
    logic [ANG_W-1:0] view_angle_diff = '0;
    logic [1:0]       wall_side = '0;
    logic [TEXW-1:0]  tex_column = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  kind;
    logic [31:0] pixel_offset, color, texel_offset;
    logic [1:0]  texture_select;
    logic [TEXW-1:0] tex_row;

    raycast_column_pixel_shader_top dut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predictor's copy of the register file
    longint unsigned scr_h = 480, cell_len = 64, tex_h = 64, ceil_col = 0, floor_col = 0;
    longint unsigned stride = 2560, tex_stride = 256, pix_bytes = 4;

    pixel_t pending_pixels[$];
    shade_t expected_shades[$];
    logic   quiet = 1'b0;       // no idling in the final stretch
    int     mismatches = 0;
    longint cycles = 0;

    // cosine in Q1.16 by truncated Taylor series; returns 0 past a quarter turn
    function automatic bit cosine_q16(input longint unsigned ang, output longint unsigned c16);
        longint unsigned n, quarter, half, a, x, x2, term;
        longint sum;
        bit neg;
        n = 64'd1 << ANG_W;
        quarter = n >> 2;
        half = n >> 1;
        a = ang & (n - 1);
        if (a > half) a = n - a;
        neg = a > quarter;
        if (neg) a = half - a;
        x = a * HALF_PI_Q30 / quarter;
        x2 = (x * x) >> 30;
        term = ONE_Q30;
        sum = ONE_Q30;
        for (int k = 1; k <= 7; k++)
        begin
            term = ((term * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
            if (k & 1) sum -= longint'(term);
            else       sum += longint'(term);
        end
        if (sum < 0) sum = 0;
        c16 = (longint'(sum) + 8192) >> 14;
        if (c16 > COS_ONE_Q16) c16 = COS_ONE_Q16;
        return !neg;
    endfunction

    function automatic shade_t shade_pixel(input pixel_t p);
        shade_t r;
        longint unsigned c16, d, ty;
        longint s, s256, h, o, hw, ow, h2, o2, r256, num, base;
        bit clip, wall, ceil_hit, floor_hit;
        ty = 0;
        s = longint'(scr_h);
        s256 = s * 256;
        r256 = longint'(p.row) * 256;
        if (cosine_q16(p.angle, c16)) d = (longint'(p.ray_dist) * c16) >> 16;
        else d = 1;
        if (d == 0) d = 1;
        h = longint'((cell_len * scr_h * 65536) / d);
        o = (s >> 1) * 256 - (h >> 1);
        if (o < 0) o = 0;
        clip = h > s256;
        if (clip)
        begin
            hw = s256; ow = 0; h2 = s256; o2 = (s >> 1) * 256 - s * 128;
        end
        else
        begin
            hw = h; ow = o; h2 = h; o2 = o;
        end
        wall = longint'(p.row) >= (ow >>> 8) && r256 < ow + hw;
        if (wall)
        begin
            num = clip ? ((h - s256) >>> 1) + r256 : r256 - ow;
            if (num > 0 && h > 0) ty = (longint'(num) * tex_h) / longint'(h);
        end
        ceil_hit = r256 < s256 - (h2 + o2);
        base = (h2 + o2) >>> 8;
        floor_hit = longint'(p.row) >= base && (longint'(p.row) - base) * 256 < o2 - 256;
        r = '0;
        r.kind = floor_hit ? KIND_FLOOR : ceil_hit ? KIND_CEIL : wall ? KIND_WALL : KIND_NONE;
        r.pix_off = 32'(longint'(p.row) * stride + longint'(p.column) * pix_bytes);
        if (r.kind == KIND_FLOOR) r.color = 32'(floor_col);
        if (r.kind == KIND_CEIL)  r.color = 32'(ceil_col);
        if (r.kind == KIND_WALL)
        begin
            r.tsel = p.side ^ 2'd2;
            r.trow = TEXW'(ty);
            r.texel_off = 32'(ty * tex_stride + longint'(p.tcol) * pix_bytes);
        end
        return r;
    endfunction

    task automatic reg_write(input logic [2:0] idx, input longint unsigned val);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= 32'(val);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_SCREEN_HEIGHT:   scr_h = val & 11'h7FF;
            REG_CELL_SIZE:       cell_len = val & 12'hFFF;
            REG_TEX_HEIGHT:      tex_h = val & 10'h3FF;
            REG_CEILING_COLOR:   ceil_col = val & 32'hFFFFFFFF;
            REG_FLOOR_COLOR:     floor_col = val & 32'hFFFFFFFF;
            REG_LINE_STRIDE:     stride = val & 16'hFFFF;
            REG_TEX_LINE_STRIDE: tex_stride = val & 16'hFFFF;
            default:             pix_bytes = val & 4'hF;
        endcase
    endtask

    // block drained: queues empty, then the pipeline left to run dry
    task automatic wait_drained();
        while (pending_pixels.size() != 0 || expected_shades.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic pixel_t random_pixel();
        pixel_t p;
        p = '0;
        // rows mostly on screen, sometimes anywhere
        p.row = ($urandom_range(0, 3) == 0) ? ROW_W'($urandom)
                                            : ROW_W'($urandom_range(0, scr_h));
        p.column = 12'($urandom);
        case ($urandom_range(0, 3))
            0: p.ray_dist = 24'($urandom_range(1, 4096));
            1: p.ray_dist = 24'($urandom_range(1, 24'hFFFFFF));
            default: p.ray_dist = 24'($urandom_range(256, 256 * 64 * 16));
        endcase
        // angles mostly near straight ahead
        p.angle = ($urandom_range(0, 4) == 0) ? ANG_W'($urandom)
                                              : ANG_W'($urandom_range(0, 900) - 450);
        p.side = 2'($urandom);
        p.tcol = TEXW'($urandom);
        return p;
    endfunction

    task automatic push_pixel(input pixel_t p);
        pending_pixels.push_back(p);
    endtask

    task automatic random_config();
        reg_write(REG_SCREEN_HEIGHT, $urandom_range(1, 2047));
        reg_write(REG_CELL_SIZE, $urandom_range(1, 4095));
        reg_write(REG_TEX_HEIGHT, $urandom_range(0, 1023));
        reg_write(REG_CEILING_COLOR, $urandom);
        reg_write(REG_FLOOR_COLOR, $urandom);
        reg_write(REG_LINE_STRIDE, $urandom_range(1, 65535));
        reg_write(REG_TEX_LINE_STRIDE, $urandom_range(1, 65535));
        reg_write(REG_PIXEL_BYTES, $urandom_range(0, 15));
    endtask

    // stimulus: directed corners, then random phases under several settings
    initial
    begin
        pixel_t p;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        reg_write(REG_CEILING_COLOR, 32'hA5A5_0F0F);
        reg_write(REG_FLOOR_COLOR, 32'h5A5A_F0F0);
        // straight ahead, sweep of rows across ceiling, wall and floor
        for (int r = 0; r < 8; r++)
        begin
            p = '{row: ROW_W'(r * 68), column: 12'(r * 500), ray_dist: 24'(256 * 100),
                  angle: '0, side: 2'(r), tcol: TEXW'(r * 130)};
            push_pixel(p);
        end
        // extremes: min/max distance, quarter turn, beyond, max fields
        push_pixel('{row: '0, column: '0, ray_dist: 24'd1, angle: '0, side: 0, tcol: '0});
        push_pixel('{row: 11'd240, column: 12'hFFF, ray_dist: 24'd1, angle: '0, side: 3,
                     tcol: 10'h3FF});
        push_pixel('{row: 11'h7FF, column: 12'hFFF, ray_dist: 24'hFFFFFF, angle: 12'hFFF,
                     side: 1, tcol: 10'h3FF});
        push_pixel('{row: 11'd240, column: 12'd7, ray_dist: 24'd5000, angle: 12'd1024,
                     side: 2, tcol: 10'd5});
        push_pixel('{row: 11'd240, column: 12'd7, ray_dist: 24'd5000, angle: 12'd2048,
                     side: 2, tcol: 10'd5});
        push_pixel('{row: 11'd100, column: 12'd9, ray_dist: 24'd40000, angle: 12'd3000,
                     side: 1, tcol: 10'd9});
        push_pixel('{row: 11'd479, column: 12'd1, ray_dist: 24'hFFFFFF, angle: 12'd1023,
                     side: 0, tcol: 10'd1});
        push_pixel('{row: 11'd300, column: 12'd2, ray_dist: 24'd16384, angle: 12'd2, side: 3,
                     tcol: 10'd2});
        push_pixel('{row: 11'd2000, column: 12'd3, ray_dist: 24'd3000, angle: 12'd4090,
                     side: 0, tcol: 10'd3});
        wait_drained();

        // zero texture height and zero pixel size, then the smallest settings
        reg_write(REG_TEX_HEIGHT, 0);
        reg_write(REG_PIXEL_BYTES, 0);
        for (int i = 0; i < 4; i++) push_pixel(random_pixel());
        wait_drained();
        reg_write(REG_SCREEN_HEIGHT, 1);
        reg_write(REG_CELL_SIZE, 1);
        reg_write(REG_TEX_HEIGHT, 1);
        reg_write(REG_LINE_STRIDE, 1);
        reg_write(REG_TEX_LINE_STRIDE, 1);
        reg_write(REG_PIXEL_BYTES, 1);
        for (int i = 0; i < 60; i++) push_pixel(random_pixel());
        wait_drained();

        // largest settings
        reg_write(REG_SCREEN_HEIGHT, 2047);
        reg_write(REG_CELL_SIZE, 4095);
        reg_write(REG_TEX_HEIGHT, 1023);
        reg_write(REG_CEILING_COLOR, 32'hFFFF_FFFF);
        reg_write(REG_FLOOR_COLOR, 32'hFFFF_FFFF);
        reg_write(REG_LINE_STRIDE, 65535);
        reg_write(REG_TEX_LINE_STRIDE, 65535);
        reg_write(REG_PIXEL_BYTES, 15);
        for (int i = 0; i < 150; i++) push_pixel(random_pixel());
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            random_config();
            for (int i = 0; i < 150; i++) push_pixel(random_pixel());
            wait_drained();
        end

        // back to defaults-like settings; last part without idling
        reg_write(REG_SCREEN_HEIGHT, 480);
        reg_write(REG_CELL_SIZE, 64);
        reg_write(REG_TEX_HEIGHT, 64);
        reg_write(REG_LINE_STRIDE, 2560);
        reg_write(REG_TEX_LINE_STRIDE, 256);
        reg_write(REG_PIXEL_BYTES, 4);
        for (int i = 0; i < 100; i++) push_pixel(random_pixel());
        wait_drained();
        quiet = 1'b1;
        for (int i = 0; i < 100; i++) push_pixel(random_pixel());
        wait_drained();

        if (mismatches == 0)
            $display("raycast_column_pixel_shader_top_tb: PASS");
        else
            $display("raycast_column_pixel_shader_top_tb: FAIL");
        $finish;
    end

    // driver: one transfer per accepted handshake, idle bursts between
    int src_idle = 0;
    always @(posedge clk)
    begin
        pixel_t p;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                expected_shades.push_back(shade_pixel(pending_pixels.pop_front()));
                if (!quiet && $urandom_range(0, 9) == 0) src_idle = $urandom_range(1, 14);
            end
            if (src_idle > 0)
            begin
                src_idle--;
                in_valid <= 1'b0;
            end
            else if (pending_pixels.size() != 0)
            begin
                p = pending_pixels[0];
                in_valid <= 1'b1;
                row <= p.row; column <= p.column; ray_dist <= p.ray_dist;
                view_angle_diff <= p.angle; wall_side <= p.side; tex_column <= p.tcol;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor: compare each result transfer with the oldest prediction
    int sink_idle = 0;
    always @(posedge clk)
    begin
        shade_t got, want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = '{kind, pixel_offset, color, texture_select, tex_row, texel_offset};
                if (expected_shades.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %p", got);
                end
                else
                begin
                    want = expected_shades.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p, got %p", want, got);
                    end
                end
            end
            if (sink_idle > 0)
            begin
                sink_idle--;
                out_ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 11) == 0)
            begin
                sink_idle = $urandom_range(0, 13);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("raycast_column_pixel_shader_top_tb: FAIL");
            $finish;
        end
    end

endmodule
